// ===== design/mt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mt_pkg
// Constants and word functions shared by the MT19937 generator files.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned ADDR_W       = 10;

  typedef logic [31:0]       word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_WORD     = addr_t'(STATE_WORDS - 1);
  localparam addr_t FULL_INDEX    = addr_t'(STATE_WORDS);
  localparam addr_t UNSEEDED_MARK = addr_t'(STATE_WORDS + 1);
  localparam addr_t WRAP_POINT    = addr_t'(STATE_WORDS - TWIST_OFFSET);
  localparam addr_t FAR_STEP      = addr_t'(TWIST_OFFSET);
  localparam addr_t WARMUP_LAST   = addr_t'(50);

  localparam word_t LCG_MUL      = 32'd69069;
  localparam word_t TWIST_MATRIX = 32'h9908b0df;
  localparam word_t HIGH_BIT     = 32'h80000000;
  localparam word_t LOW_BITS     = 32'h7fffffff;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;

  // One twist step: top bit of a, low bits of b, folded into the far word
  function automatic word_t mix_word(input word_t a, input word_t b, input word_t far);
    word_t y;
    word_t r;
    y = (a & HIGH_BIT) | (b & LOW_BITS);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TWIST_MATRIX;
    end
    return r;
  endfunction

  // Output tempering
  function automatic word_t temper(input word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage
`default_nettype wire

// ===== design/mt_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mt_out_stage
// Tempers a raw state word and holds it in the output register until the
// downstream side takes the transfer.
// ----------------------------------------------------------------------------
module mt_out_stage
  import mt_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   load,
  input  word_t raw_word,
  output logic  can_load,
  output logic  out_valid,
  input  wire   out_stall,
  output word_t random_word
);

  // Register is free when empty or being drained this cycle
  assign can_load = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && can_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      random_word <= temper(raw_word);
    end
  end

endmodule
`default_nettype wire

// ===== design/mt19937_random_word_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_random_word_generator
// MT19937 word generator with 69069 LCG seeding, state held in one RAM.
// ----------------------------------------------------------------------------
// func 0 seeds the generator and gives no result; func 1 returns one
// tempered word. Items are taken one at a time: a seed keeps intake stalled
// through 51 warm-up LCG steps, then one RAM write per word. A word request
// passes the RAM read, the read wait and the output state, where it waits
// for the output register; when the state is used up it is first regenerated
// by a read-then-write loop per word over the two-read-port state RAM. A
// request before any seed first seeds from default_seed. The output register
// lets the next item be taken while a result still waits downstream. Real
// value = word / 2^32.
// ----------------------------------------------------------------------------
module mt19937_random_word_generator
  import mt_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  // configuration write
  input  wire   cfg_valid,
  output logic  cfg_ready,
  input  word_t cfg_data,
  // input items
  input  wire   in_valid,
  output logic  in_stall,
  input  wire   func,
  input  word_t seed_value,
  // results
  output logic  out_valid,
  input  wire   out_stall,
  output word_t random_word
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WARM  = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd2;
  localparam logic [3:0] S_TWLD  = 4'd3;
  localparam logic [3:0] S_TWLDW = 4'd4;
  localparam logic [3:0] S_TWRD  = 4'd5;
  localparam logic [3:0] S_TWWR  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_RDW   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  addr_t      word_index;
  addr_t      cnt;
  word_t      lcg_s;
  word_t      cur;
  word_t      raw;
  word_t      default_seed;
  logic       gen_pend;

  word_t      mem [STATE_WORDS];
  addr_t      addr_a;
  addr_t      addr_b;
  word_t      rdata_a;
  word_t      rdata_b;
  logic       mem_we;
  addr_t      waddr;
  word_t      wdata;

  word_t      lcg_step;
  word_t      mixed;
  logic       out_load;
  logic       out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign lcg_step  = lcg_s * LCG_MUL + 32'd1;
  assign mixed     = mix_word(cur, rdata_a, rdata_b);
  assign out_load  = (state == S_OUT);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_seed <= 32'd1234;
    end else if (cfg_valid && cfg_ready) begin
      default_seed <= cfg_data;
    end
  end

  // RAM address and write selection
  always_comb begin
    addr_a = word_index;
    addr_b = cnt;
    mem_we = 1'b0;
    waddr  = cnt;
    wdata  = lcg_step;
    unique case (state)
      S_FILL: begin
        mem_we = 1'b1;
      end
      S_TWLD: begin
        addr_a = '0;
      end
      S_TWRD: begin
        addr_a = (cnt == LAST_WORD) ? '0 : cnt + addr_t'(1);
        addr_b = (cnt < WRAP_POINT) ? cnt + FAR_STEP : cnt - WRAP_POINT;
      end
      S_TWWR: begin
        mem_we = 1'b1;
        wdata  = mixed;
      end
      default: begin
      end
    endcase
  end

  // State RAM: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_index <= UNSEEDED_MARK;
      cnt        <= '0;
      gen_pend   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            if (!func) begin
              lcg_s    <= seed_value;
              gen_pend <= 1'b0;
              state    <= S_WARM;
            end else if (word_index == UNSEEDED_MARK) begin
              lcg_s    <= default_seed;
              gen_pend <= 1'b1;
              state    <= S_WARM;
            end else if (word_index >= FULL_INDEX) begin
              state <= S_TWLD;
            end else begin
              state <= S_RD;
            end
          end
        end
        // 50 warm-up steps and the discarded value
        S_WARM: begin
          lcg_s <= lcg_step;
          if (cnt == WARMUP_LAST) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= cnt + addr_t'(1);
          end
        end
        S_FILL: begin
          lcg_s <= lcg_step;
          if (cnt == LAST_WORD) begin
            word_index <= FULL_INDEX;
            cnt        <= '0;
            state      <= gen_pend ? S_TWLD : S_IDLE;
          end else begin
            cnt <= cnt + addr_t'(1);
          end
        end
        S_TWLD: begin
          state <= S_TWLDW;
        end
        S_TWLDW: begin
          cur   <= rdata_a;
          cnt   <= '0;
          state <= S_TWRD;
        end
        S_TWRD: begin
          state <= S_TWWR;
        end
        // next word, whose low bits fed this step, carries over as the following top
        S_TWWR: begin
          cur <= rdata_a;
          if (cnt == LAST_WORD) begin
            word_index <= '0;
            state      <= S_RD;
          end else begin
            cnt   <= cnt + addr_t'(1);
            state <= S_TWRD;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          raw        <= rdata_a;
          word_index <= word_index + addr_t'(1);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Tempering and output register
  mt_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (out_load),
    .raw_word    (raw),
    .can_load    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  // Checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("state RAM written while idle");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    word_index <= UNSEEDED_MARK)
    else $error("word index out of range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("intake not closed after a transfer");

  a_read_index_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (word_index < FULL_INDEX))
    else $error("word read with exhausted index");

  a_out_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDW) |=> (state == S_OUT))
    else $error("read word not passed to output");

endmodule
`default_nettype wire

// ===== bench/mt_bench_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt_bench_pkg
// Request codes shared by the MT19937 generator bench files.
// ----------------------------------------------------------------------------
package mt_bench_pkg;

  // Meaning of the func field of an input transfer
  typedef enum logic {
    OP_SEED = 1'b0,
    OP_WORD = 1'b1
  } op_e;

endpackage

// ===== bench/mt19937_word_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_word_checker
// Watches the generator's channels, predicts each word and compares it.
// ----------------------------------------------------------------------------
// Keeps its own copy of the twister state, the word position and the default
// seed register. Every accepted word request pushes the predicted tempered
// word; every accepted output transfer is checked against the oldest one.
// ----------------------------------------------------------------------------
module mt19937_word_checker
  import mt_pkg::*;
  import mt_bench_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  word_t       cfg_data,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire         func,
  input  word_t       seed_value,
  input  wire         out_valid,
  input  wire         out_stall,
  input  word_t       random_word,
  output int unsigned words_owed,
  output int unsigned mismatches
);

  localparam word_t       SEED_AT_RESET = 32'd1234;
  localparam int unsigned WARMUP_STEPS  = 50;

  word_t       twister_copy [STATE_WORDS];
  int unsigned word_pos;
  word_t       seed_reg;
  word_t       owed_words [$];
  int unsigned err_total;

  // 69069 congruential step, modulo 2^32
  function automatic word_t lcg_step(input word_t s);
    return s * LCG_MUL + 32'd1;
  endfunction

  // Warm-up steps plus one thrown away, then one state word per step
  function automatic void load_seed(input word_t seed);
    word_t s;
    int    k;
    s = seed;
    for (k = 0; k <= WARMUP_STEPS; k++) begin
      s = lcg_step(s);
    end
    for (k = 0; k < STATE_WORDS; k++) begin
      s = lcg_step(s);
      twister_copy[k] = s;
    end
    word_pos = STATE_WORDS;
  endfunction

  // Full regeneration pass, in place, in index order
  function automatic void regenerate();
    word_t y;
    int    k;
    for (k = 0; k < STATE_WORDS; k++) begin
      y = {twister_copy[k][31], twister_copy[(k + 1) % STATE_WORDS][30:0]};
      twister_copy[k] = twister_copy[(k + TWIST_OFFSET) % STATE_WORDS]
                        ^ {1'b0, y[31:1]} ^ (y[0] ? TWIST_MATRIX : 32'h0);
    end
  endfunction

  function automatic word_t tempered(input word_t raw);
    word_t t;
    t = raw ^ {11'b0, raw[31:11]};
    t = t ^ ({t[24:0], 7'b0} & TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & TEMPER_C);
    return t ^ {18'b0, t[31:18]};
  endfunction

  // Next word; seeds from the register if never seeded, regenerates when used up
  function automatic word_t next_word();
    word_t w;
    if (word_pos == UNSEEDED_MARK) begin
      load_seed(seed_reg);
    end
    if (word_pos >= STATE_WORDS) begin
      regenerate();
      word_pos = 0;
    end
    w = tempered(twister_copy[word_pos]);
    word_pos = word_pos + 1;
    return w;
  endfunction

  // Output checked before intake: a word cannot leave on the edge it is asked for
  always @(posedge clk) begin : track
    word_t want;
    if (rst) begin
      seed_reg  = SEED_AT_RESET;
      word_pos  = UNSEEDED_MARK;
      err_total = 0;
      owed_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (owed_words.size() == 0) begin
          err_total++;
          $display("%0t: random_word expected none, got %h", $time, random_word);
        end else begin
          want = owed_words.pop_front();
          if (random_word !== want) begin
            err_total++;
            $display("%0t: random_word expected %h, got %h", $time, want, random_word);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (func == OP_SEED) begin
          load_seed(seed_value);
        end else begin
          owed_words.push_back(next_word());
        end
      end
    end
    words_owed <= owed_words.size();
    mismatches <= err_total;
  end

endmodule

// ===== bench/mt19937_random_word_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_random_word_generator_tb
// Stimulus and verdict for the MT19937 word generator.
// ----------------------------------------------------------------------------
// Writes the default seed register at quiet points, drives seed and word
// requests with random gaps, stalls the result side at random and once for a
// long stretch, and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module mt19937_random_word_generator_tb;
  import mt_pkg::*;
  import mt_bench_pkg::*;

  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned SETTLE_CYCLES  = 2000;  // a seed plus a full regeneration
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  word_t       cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  word_t       seed_value;
  logic        out_valid;
  logic        out_stall;
  word_t       random_word;
  int unsigned words_owed;
  int unsigned mismatches;
  int unsigned hold_asks;
  int unsigned sent;
  bit          eager;

  always #5 clk = ~clk;

  mt19937_random_word_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
  );

  mt19937_word_checker word_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .seed_value  (seed_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word),
    .words_owed  (words_owed),
    .mismatches  (mismatches)
  );

  // One input transfer; valid stays high afterwards so back-to-back items need no gap
  task automatic send_item(input op_e op, input word_t s);
    int unsigned gap;
    gap = (eager || (sent % 96) < 24) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= op;
    seed_value <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic write_default_seed(input word_t v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed word, then let a seed or regeneration finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall per transfer, calm stretches, long hold on request
  initial begin : result_side
    int unsigned gap;
    int unsigned served;
    int unsigned taken;
    served = 0;
    taken  = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asks != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = ((taken % 80) >= 60) ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_asks == served) @(posedge clk);
      if (out_valid) begin
        taken++;
      end
    end
  end

  // Watchdog: too long without any transfer on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
          || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    sent  = 0;
    eager = 1'b0;
    rst        <= 1'b1;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    func       <= OP_SEED;
    seed_value <= '0;
    hold_asks  <= 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Register at its top value, then words before any seed use it
    write_default_seed(32'hffff_ffff);
    send_item(OP_WORD, 32'h0);
    send_item(OP_WORD, $urandom());

    // Seed extremes, each followed by a word that forces a regeneration
    send_item(OP_SEED, 32'h0000_0000);
    send_item(OP_WORD, 32'hffff_ffff);
    send_item(OP_SEED, 32'hffff_ffff);
    send_item(OP_WORD, 32'h0);
    send_item(OP_SEED, 32'h8000_0000);
    send_item(OP_WORD, $urandom());
    send_item(OP_SEED, 32'h0000_0001);
    send_item(OP_WORD, $urandom());
    send_item(OP_SEED, 32'h7fff_ffff);
    send_item(OP_WORD, $urandom());
    // back-to-back seeds: the second one wins
    send_item(OP_SEED, 32'h5555_5555);
    send_item(OP_SEED, 32'haaaa_aaaa);
    send_item(OP_WORD, $urandom());
    send_item(OP_WORD, $urandom());
    send_item(OP_SEED, 32'd1234);
    send_item(OP_WORD, $urandom());
    drain_and_settle();

    // Mixed seeds and short runs of words
    write_default_seed(32'h0000_0000);
    for (n = 0; n < 420; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_item(OP_SEED, $urandom());
      end else begin
        send_item(OP_WORD, $urandom());
      end
    end
    drain_and_settle();

    // Back-pressure: results held off while requests keep coming
    write_default_seed($urandom());
    eager = 1'b1;
    hold_asks <= hold_asks + 1;
    for (n = 0; n < 24; n++) begin
      send_item(OP_WORD, $urandom());
    end
    eager = 1'b0;
    drain_and_settle();

    // Long runs that cross the end of the state more than once
    send_item(OP_SEED, $urandom());
    for (n = 0; n < 700; n++) begin
      send_item(OP_WORD, $urandom());
    end
    for (n = 0; n < 500; n++) begin
      if ($urandom_range(0, 99) == 0) begin
        send_item(OP_SEED, $urandom());
      end else begin
        send_item(OP_WORD, $urandom());
      end
    end
    drain_and_settle();

    if (mismatches == 0 && words_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
